// ----- src/mic_rms_pkg.sv -----
// shared constants and types for the microphone rms level meter
`timescale 1ns / 1ps

package mic_rms_pkg;

  localparam int MAX_CHUNK_DEF = 512;
  localparam int QUEUE_DEPTH   = 2;

  localparam int RAW_W   = 32;
  localparam int PCM_W   = 16;
  localparam int PCM_LSB = 14;
  localparam int MAG_W   = 17;
  localparam int SQ_W    = 31;
  localparam int LEVEL_W = 17;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'd65536;

  // quotient of 4*sum/n never exceeds 2^32, its root never exceeds 2^16
  localparam int QUOT_W    = 33;
  localparam int RAD_W     = 34;
  localparam int ROOT_W    = 17;
  localparam int SQ_REM_W  = ROOT_W + 2;
  localparam int SQ_STEPS  = RAD_W / 2;

  // floor(x/10) as (x * RECIP_10) >> RECIP_SH, exact for x below 2^20
  localparam int NUM_W    = 20;
  localparam int RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP_10 = 20'd838861;
  localparam int RECIP_SH = 23;
  localparam int PROD_W   = NUM_W + RECIP_W;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_MIX,
    BK_SCALE,
    BK_DONE
  } back_state_e;

endpackage

// ----- src/mic_rms_front.sv -----
// front end: pcm extraction, squaring, chunk accumulation and close detection
`timescale 1ns / 1ps

module mic_rms_front #(
  parameter int MAX_CHUNK = mic_rms_pkg::MAX_CHUNK_DEF,
  parameter int SUM_W     = 31 + $clog2(MAX_CHUNK),
  parameter int CNT_W     = $clog2(MAX_CHUNK + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_enable_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mic_rms_pkg::RAW_W-1:0]       raw_word_i,
  input  logic                                last_in_chunk_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output logic [mic_rms_pkg::PCM_W-1:0]       push_pcm_o,
  output logic                                push_closed_o,
  output logic [SUM_W-1:0]                    push_sum_o,
  output logic [CNT_W-1:0]                    push_cnt_o
);

  logic                               en_q;
  logic                               s1_vld_q, s1_vld_d;
  logic [mic_rms_pkg::PCM_W-1:0]      s1_pcm_q;
  logic                               s1_last_q;
  logic [mic_rms_pkg::SQ_W-1:0]       s1_sq_q;
  logic [SUM_W-1:0]                   sum_q, sum_d;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;

  logic                               in_acc;
  logic                               push;
  logic [mic_rms_pkg::PCM_W-1:0]      pcm;
  logic [mic_rms_pkg::MAG_W-1:0]      mag;
  logic [2*mic_rms_pkg::MAG_W-1:0]    sq_full;
  logic [SUM_W-1:0]                   sum_new;
  logic [CNT_W-1:0]                   cnt_new;
  logic                               closed;

  assign in_stall_o = s1_vld_q & ~push_ready_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign push       = s1_vld_q & push_ready_i;

  assign pcm     = raw_word_i[mic_rms_pkg::PCM_LSB +: mic_rms_pkg::PCM_W];
  assign mag     = pcm[mic_rms_pkg::PCM_W-1]
                 ? (mic_rms_pkg::MAG_W'(17'h10000) - {1'b0, pcm})
                 : {1'b0, pcm};
  assign sq_full = mag * mag;

  assign sum_new = sum_q + SUM_W'(s1_sq_q);
  assign cnt_new = cnt_q + CNT_W'(1);
  assign closed  = s1_last_q | (cnt_new == CNT_W'(MAX_CHUNK));

  assign push_valid_o  = s1_vld_q;
  assign push_pcm_o    = s1_pcm_q;
  assign push_closed_o = closed;
  assign push_sum_o    = sum_new;
  assign push_cnt_o    = cnt_new;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc && en_q) begin
      s1_vld_d = 1'b1;
    end else if (push) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (push) begin
      sum_d = closed ? '0 : sum_new;
      cnt_d = closed ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      s1_vld_q <= 1'b0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_enable_i;
      end
      s1_vld_q <= s1_vld_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && en_q) begin
      s1_pcm_q  <= pcm;
      s1_last_q <= last_in_chunk_i;
      s1_sq_q   <= sq_full[mic_rms_pkg::SQ_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_cnt_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(MAX_CHUNK))
    else $error("chunk count reached the limit without closing");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q)
    else $error("stall raised with no held request");

  a_square_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> s1_sq_q <= mic_rms_pkg::SQ_W'(31'h40000000))
    else $error("square out of range");
`endif

endmodule

// ----- src/mic_rms_fifo.sv -----
// short request queue between the front and back ends
`timescale 1ns / 1ps

module mic_rms_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mic_rms_pkg::QUEUE_DEPTH,
  parameter int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              wr_en, rd_en;

  assign wr_ready_o = cnt_q != CNT_W'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign wr_en      = wr_valid_i & wr_ready_o;
  assign rd_en      = rd_valid_o & rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- src/mic_rms_back.sv -----
// back end: mean-square divide, square root, smoothing and output register
`timescale 1ns / 1ps

module mic_rms_back #(
  parameter int MAX_CHUNK = mic_rms_pkg::MAX_CHUNK_DEF,
  parameter int SUM_W     = 31 + $clog2(MAX_CHUNK),
  parameter int CNT_W     = $clog2(MAX_CHUNK + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  req_valid_i,
  output logic                                  req_pop_o,
  input  logic [mic_rms_pkg::PCM_W-1:0]         req_pcm_i,
  input  logic                                  req_closed_i,
  input  logic [SUM_W-1:0]                      req_sum_i,
  input  logic [CNT_W-1:0]                      req_cnt_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mic_rms_pkg::PCM_W-1:0]         pcm_sample_o,
  output logic [mic_rms_pkg::LEVEL_W-1:0]       level_o,
  output logic                                  level_updated_o
);

  localparam int DVD_W  = SUM_W + 2;
  localparam int STEP_W = $clog2(DVD_W);

  mic_rms_pkg::back_state_e state_q, state_d;

  logic [STEP_W-1:0]                    step_q;
  logic [DVD_W-1:0]                     dvd_q;
  logic [CNT_W-1:0]                     rem_q;
  logic [CNT_W-1:0]                     div_q;
  logic [mic_rms_pkg::RAD_W-1:0]        rad_q;
  logic [mic_rms_pkg::SQ_REM_W-1:0]     sq_rem_q;
  logic [mic_rms_pkg::ROOT_W-1:0]       root_q;
  logic [mic_rms_pkg::NUM_W-1:0]        num_q;
  logic [mic_rms_pkg::PROD_W-1:0]       prod_q;
  logic [mic_rms_pkg::PCM_W-1:0]        pcm_q;
  logic [mic_rms_pkg::LEVEL_W-1:0]      level_q;

  logic                                 out_valid_q;
  logic [mic_rms_pkg::PCM_W-1:0]        out_pcm_q;
  logic [mic_rms_pkg::LEVEL_W-1:0]      out_level_q;
  logic                                 out_upd_q;

  logic                                 out_free;
  logic                                 out_load;
  logic                                 out_upd;

  logic [CNT_W:0]                       rem_sh;
  logic                                 div_ge;
  logic [CNT_W-1:0]                     rem_next;
  logic [DVD_W-1:0]                     dvd_next;

  logic [mic_rms_pkg::SQ_REM_W+1:0]     sq_sh;
  logic [mic_rms_pkg::SQ_REM_W+1:0]     sq_trial;
  logic                                 sq_ge;
  logic [mic_rms_pkg::SQ_REM_W+1:0]     sq_diff;

  logic [mic_rms_pkg::LEVEL_W-1:0]      lv_raw;
  logic [mic_rms_pkg::LEVEL_W-1:0]      lv_new;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // restoring divide, one quotient bit per cycle
  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_q};
  assign rem_next = div_ge ? CNT_W'(rem_sh - {1'b0, div_q}) : CNT_W'(rem_sh);
  assign dvd_next = {dvd_q[DVD_W-2:0], div_ge};

  // digit-by-digit square root, one root bit per cycle
  assign sq_sh    = {sq_rem_q, rad_q[mic_rms_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;

  assign lv_raw = prod_q[mic_rms_pkg::RECIP_SH +: mic_rms_pkg::LEVEL_W];
  assign lv_new = (lv_raw > mic_rms_pkg::LEVEL_FULL) ? mic_rms_pkg::LEVEL_FULL : lv_raw;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mic_rms_pkg::BK_IDLE: begin
        if (req_valid_i && req_closed_i) begin
          state_d = mic_rms_pkg::BK_DIV;
        end
      end
      mic_rms_pkg::BK_DIV: begin
        if (step_q == '0) begin
          state_d = mic_rms_pkg::BK_SQRT;
        end
      end
      mic_rms_pkg::BK_SQRT: begin
        if (step_q == '0) begin
          state_d = mic_rms_pkg::BK_MIX;
        end
      end
      mic_rms_pkg::BK_MIX:   state_d = mic_rms_pkg::BK_SCALE;
      mic_rms_pkg::BK_SCALE: state_d = mic_rms_pkg::BK_DONE;
      mic_rms_pkg::BK_DONE: begin
        if (out_free) begin
          state_d = mic_rms_pkg::BK_IDLE;
        end
      end
      default: state_d = mic_rms_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    req_pop_o = 1'b0;
    out_load  = 1'b0;
    out_upd   = 1'b0;
    unique case (state_q)
      mic_rms_pkg::BK_IDLE: begin
        req_pop_o = req_valid_i & (req_closed_i | out_free);
        out_load  = req_valid_i & ~req_closed_i & out_free;
      end
      mic_rms_pkg::BK_DONE: begin
        out_load = out_free;
        out_upd  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mic_rms_pkg::BK_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        level_q <= '0;
      end else if (out_upd) begin
        level_q <= lv_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mic_rms_pkg::BK_IDLE: begin
        dvd_q  <= {req_sum_i, 2'b00};
        div_q  <= req_cnt_i;
        rem_q  <= '0;
        pcm_q  <= req_pcm_i;
        step_q <= STEP_W'(DVD_W - 1);
      end
      mic_rms_pkg::BK_DIV: begin
        dvd_q <= dvd_next;
        rem_q <= rem_next;
        if (step_q == '0) begin
          rad_q    <= mic_rms_pkg::RAD_W'(dvd_next[mic_rms_pkg::QUOT_W-1:0]);
          sq_rem_q <= '0;
          root_q   <= '0;
          step_q   <= STEP_W'(mic_rms_pkg::SQ_STEPS - 1);
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
      mic_rms_pkg::BK_SQRT: begin
        rad_q    <= {rad_q[mic_rms_pkg::RAD_W-3:0], 2'b00};
        sq_rem_q <= sq_ge ? mic_rms_pkg::SQ_REM_W'(sq_diff) : mic_rms_pkg::SQ_REM_W'(sq_sh);
        root_q   <= {root_q[mic_rms_pkg::ROOT_W-2:0], sq_ge};
        step_q   <= step_q - STEP_W'(1);
      end
      mic_rms_pkg::BK_MIX: begin
        num_q <= mic_rms_pkg::NUM_W'(level_q) * mic_rms_pkg::NUM_W'(7)
               + mic_rms_pkg::NUM_W'(root_q) * mic_rms_pkg::NUM_W'(3);
      end
      mic_rms_pkg::BK_SCALE: begin
        prod_q <= mic_rms_pkg::PROD_W'(num_q) * mic_rms_pkg::PROD_W'(mic_rms_pkg::RECIP_10);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_upd_q <= out_upd;
      if (out_upd) begin
        out_pcm_q   <= pcm_q;
        out_level_q <= lv_new;
      end else begin
        out_pcm_q   <= req_pcm_i;
        out_level_q <= level_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pcm_sample_o    = out_pcm_q;
  assign level_o         = out_level_q;
  assign level_updated_o = out_upd_q;

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= mic_rms_pkg::LEVEL_FULL)
    else $error("smoothed level above full scale");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mic_rms_pkg::BK_DIV |-> div_q != '0)
    else $error("divide by a zero sample count");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mic_rms_pkg::BK_DIV |-> rem_q < div_q)
    else $error("divider remainder out of range");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |-> req_valid_i)
    else $error("pop from an empty queue");
`endif

endmodule

// ----- src/mic_sample_rms_level_meter.sv -----
// top level of the microphone rms level meter
// path: a sample that does not close a chunk passes the front register, the queue
// and the output register; a chunk-closing sample also passes the back end's
// bit-serial divider and square root, smoothing and scaling, which hold later ones
// throughput: one sample per cycle between chunk ends while out_stall_i is low
// reset: asynchronous active low; clears enable, sums, count, level and all valids
`timescale 1ns / 1ps

module mic_sample_rms_level_meter #(
  parameter int MAX_CHUNK = mic_rms_pkg::MAX_CHUNK_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  capture_enable_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [mic_rms_pkg::RAW_W-1:0]  raw_word_i,
  input  logic                                  last_in_chunk_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mic_rms_pkg::PCM_W-1:0]  pcm_sample_o,
  output logic [mic_rms_pkg::LEVEL_W-1:0]       level_o,
  output logic                                  level_updated_o
);

  localparam int SUM_W  = 31 + $clog2(MAX_CHUNK);
  localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
  localparam int REQ_W  = mic_rms_pkg::PCM_W + 1 + SUM_W + CNT_W;

  logic                               cfg_we;
  logic                               push_valid, push_ready;
  logic [mic_rms_pkg::PCM_W-1:0]      push_pcm;
  logic                               push_closed;
  logic [SUM_W-1:0]                   push_sum;
  logic [CNT_W-1:0]                   push_cnt;
  logic                               req_valid, req_pop;
  logic [REQ_W-1:0]                   req_data;
  logic [mic_rms_pkg::PCM_W-1:0]      pcm_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  mic_rms_front #(
    .MAX_CHUNK (MAX_CHUNK),
    .SUM_W     (SUM_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_enable_i    (capture_enable_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_word_i      (raw_word_i),
    .last_in_chunk_i (last_in_chunk_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_pcm_o      (push_pcm),
    .push_closed_o   (push_closed),
    .push_sum_o      (push_sum),
    .push_cnt_o      (push_cnt)
  );

  mic_rms_fifo #(
    .DATA_W (REQ_W),
    .DEPTH  (mic_rms_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  ({push_pcm, push_closed, push_sum, push_cnt}),
    .rd_valid_o (req_valid),
    .rd_ready_i (req_pop),
    .rd_data_o  (req_data)
  );

  mic_rms_back #(
    .MAX_CHUNK (MAX_CHUNK),
    .SUM_W     (SUM_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .req_valid_i     (req_valid),
    .req_pop_o       (req_pop),
    .req_pcm_i       (req_data[REQ_W-1 -: mic_rms_pkg::PCM_W]),
    .req_closed_i    (req_data[SUM_W + CNT_W]),
    .req_sum_i       (req_data[CNT_W +: SUM_W]),
    .req_cnt_i       (req_data[CNT_W-1:0]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pcm_sample_o    (pcm_out),
    .level_o         (level_o),
    .level_updated_o (level_updated_o)
  );

  assign pcm_sample_o = pcm_out;

endmodule
